[src/ntc_c2m_pkg.sv]
package ntc_c2m_pkg;

    // Field widths
    localparam int CODE_W = 16;
    localparam int TEMP_W = 19;

    // Breakpoint table
    localparam int STORED_POINTS      = 40;
    localparam int TABLE_POINTS_DEF   = 40;
    localparam int BASE_MILLI         = -40000;
    localparam int STEP_MILLI         = 5000;

    localparam logic [CODE_W-1:0] NTC_CODES [STORED_POINTS] = '{
        16'd7,   16'd10,  16'd14,  16'd19,  16'd26,  16'd35,  16'd47,  16'd61,
        16'd79,  16'd102, 16'd128, 16'd159, 16'd196, 16'd236, 16'd281, 16'd330,
        16'd381, 16'd433, 16'd486, 16'd538, 16'd588, 16'd636, 16'd680, 16'd721,
        16'd758, 16'd791, 16'd820, 16'd846, 16'd869, 16'd888, 16'd905, 16'd920,
        16'd933, 16'd945, 16'd955, 16'd963, 16'd970, 16'd977, 16'd983, 16'd4096
    };

    // Segment index and interpolation widths (widest span is 3113 codes)
    localparam int SEG_W       = 6;
    localparam int SPAN_W      = 12;
    localparam int D_W         = 12;
    localparam int RECIP_SHIFT = 16;
    localparam int MUL_NUM     = STEP_MILLI << RECIP_SHIFT;
    localparam int MUL_W       = 27;
    localparam int NUM_W       = 24;
    localparam int Q_W         = 13;
    localparam int QS_W        = Q_W + SPAN_W;

    // Pipeline depth
    localparam int STAGES = 7;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } t_pipe_en;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [SEG_W-1:0]  seg;
        logic              lo_clamp;
        logic              hi_clamp;
    } t_seg_beat;

endpackage

[src/ntc_c2m_in_if.sv]
interface ntc_c2m_in_if;
    logic                             valid;
    logic                             ready;
    logic [ntc_c2m_pkg::CODE_W-1:0]   raw_code;

    modport source (output valid, output raw_code, input ready);
    modport sink   (input valid, input raw_code, output ready);
endinterface

[src/ntc_c2m_out_if.sv]
interface ntc_c2m_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ntc_c2m_pkg::TEMP_W-1:0] temp_millideg;
    logic                                clamped;

    modport source (output valid, output temp_millideg, output clamped, input ready);
    modport sink   (input valid, input temp_millideg, input clamped, output ready);
endinterface

[src/ntc_c2m_ctrl.sv]
module ntc_c2m_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output ntc_c2m_pkg::t_pipe_en o_en
);

    logic [ntc_c2m_pkg::STAGES-1:0] r_vld;
    logic [ntc_c2m_pkg::STAGES-1:0] n_vld;
    logic [ntc_c2m_pkg::STAGES-1:0] w_en;

    // A stage loads when it is empty or its beat moves on; bubbles collapse
    always_comb begin
        w_en[ntc_c2m_pkg::STAGES-1] = !r_vld[ntc_c2m_pkg::STAGES-1] || i_out_ready;
        for (int k = ntc_c2m_pkg::STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (w_en[0]) begin
            n_vld[0] = i_in_valid;
        end
        for (int k = 1; k < ntc_c2m_pkg::STAGES; k++) begin
            if (w_en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_en.en     = w_en;
    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[ntc_c2m_pkg::STAGES-1];

endmodule

[src/ntc_c2m_search.sv]
module ntc_c2m_search #(
    parameter int POINTS = ntc_c2m_pkg::STORED_POINTS
) (
    input  logic                              i_clk,
    input  ntc_c2m_pkg::t_pipe_en             i_en,
    input  logic [ntc_c2m_pkg::CODE_W-1:0]    i_raw_code,
    output ntc_c2m_pkg::t_seg_beat            o_beat
);

    // One compare per inner breakpoint
    localparam int GT_W = (POINTS > 2) ? POINTS - 2 : 1;

    logic [ntc_c2m_pkg::CODE_W-1:0] r_code;
    logic [GT_W-1:0]                r_gt;
    logic [GT_W-1:0]                n_gt;
    logic                           r_lo_clamp;
    logic                           r_hi_clamp;
    logic [GT_W+1:0]                w_pad;
    logic [ntc_c2m_pkg::SEG_W-1:0]  n_seg;
    ntc_c2m_pkg::t_seg_beat         r_beat;

    // Stage 0: compare the code against every used breakpoint at once
    always_comb begin
        for (int j = 0; j < GT_W; j++) begin
            n_gt[j] = (POINTS > 2) && (i_raw_code > ntc_c2m_pkg::NTC_CODES[j+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en[0]) begin
            r_code     <= i_raw_code;
            r_gt       <= n_gt;
            r_lo_clamp <= (i_raw_code <= ntc_c2m_pkg::NTC_CODES[0]);
            r_hi_clamp <= (i_raw_code > ntc_c2m_pkg::NTC_CODES[POINTS-1]);
        end
    end

    // Stage 1: thermometer to segment index; the table rises, so one edge only
    assign w_pad = {1'b0, r_gt, 1'b1};

    always_comb begin
        n_seg = '0;
        for (int j = 0; j <= GT_W; j++) begin
            if (w_pad[j] && !w_pad[j+1]) begin
                n_seg = n_seg | ntc_c2m_pkg::SEG_W'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en[1]) begin
            r_beat.code     <= r_code;
            r_beat.seg      <= n_seg;
            r_beat.lo_clamp <= r_lo_clamp;
            r_beat.hi_clamp <= r_hi_clamp;
        end
    end

    assign o_beat = r_beat;

endmodule

[src/ntc_c2m_interp.sv]
module ntc_c2m_interp #(
    parameter int POINTS = ntc_c2m_pkg::STORED_POINTS
) (
    input  logic                                   i_clk,
    input  ntc_c2m_pkg::t_pipe_en                  i_en,
    input  ntc_c2m_pkg::t_seg_beat                 i_beat,
    output logic signed [ntc_c2m_pkg::TEMP_W-1:0]  o_temp_millideg,
    output logic                                   o_clamped
);

    localparam int SEG_N   = 1 << ntc_c2m_pkg::SEG_W;
    localparam int HI_TEMP = ntc_c2m_pkg::BASE_MILLI + ntc_c2m_pkg::STEP_MILLI * (POINTS - 1);
    localparam int TW      = ntc_c2m_pkg::TEMP_W;

    // Per-segment constants: lower code, span and scaled reciprocal
    logic [ntc_c2m_pkg::CODE_W-1:0] w_lo   [SEG_N];
    logic [ntc_c2m_pkg::SPAN_W-1:0] w_span [SEG_N];
    logic [ntc_c2m_pkg::MUL_W-1:0]  w_mul  [SEG_N];

    for (genvar g = 0; g < SEG_N; g++) begin : g_seg
        if (g >= 1 && g < ntc_c2m_pkg::STORED_POINTS) begin : g_on
            localparam int SPAN = int'(ntc_c2m_pkg::NTC_CODES[g])
                                - int'(ntc_c2m_pkg::NTC_CODES[g-1]);
            localparam int MUL  = ntc_c2m_pkg::MUL_NUM / SPAN;
            assign w_lo[g]   = ntc_c2m_pkg::NTC_CODES[g-1];
            assign w_span[g] = ntc_c2m_pkg::SPAN_W'(SPAN);
            assign w_mul[g]  = ntc_c2m_pkg::MUL_W'(MUL);
        end else begin : g_off
            assign w_lo[g]   = '0;
            assign w_span[g] = '0;
            assign w_mul[g]  = '0;
        end
    end

    // Stage 2: segment lookup and offset into segment
    logic [ntc_c2m_pkg::CODE_W-1:0]   w_diff;
    logic [ntc_c2m_pkg::D_W-1:0]      r2_d;
    logic [ntc_c2m_pkg::SPAN_W-1:0]   r2_span;
    logic [ntc_c2m_pkg::MUL_W-1:0]    r2_mul;
    logic signed [TW-1:0]             r2_base;
    logic                             r2_lo;
    logic                             r2_hi;

    assign w_diff = i_beat.code - w_lo[i_beat.seg];

    always_ff @(posedge i_clk) begin
        if (i_en.en[2]) begin
            r2_d    <= w_diff[ntc_c2m_pkg::D_W-1:0];
            r2_span <= w_span[i_beat.seg];
            r2_mul  <= w_mul[i_beat.seg];
            r2_base <= TW'(ntc_c2m_pkg::BASE_MILLI
                         + ntc_c2m_pkg::STEP_MILLI * (int'(i_beat.seg) - 1));
            r2_lo   <= i_beat.lo_clamp;
            r2_hi   <= i_beat.hi_clamp;
        end
    end

    // Stage 3: numerator and reciprocal estimate of the quotient
    logic [ntc_c2m_pkg::D_W+ntc_c2m_pkg::MUL_W-1:0] w_prod;
    logic [ntc_c2m_pkg::NUM_W-1:0]  w_num;
    logic [ntc_c2m_pkg::NUM_W-1:0]  r3_num;
    logic [ntc_c2m_pkg::Q_W-1:0]    r3_q0;
    logic [ntc_c2m_pkg::SPAN_W-1:0] r3_span;
    logic signed [TW-1:0]           r3_base;
    logic                           r3_lo;
    logic                           r3_hi;

    assign w_prod = {{ntc_c2m_pkg::MUL_W{1'b0}}, r2_d}
                  * {{ntc_c2m_pkg::D_W{1'b0}}, r2_mul};
    assign w_num  = {{(ntc_c2m_pkg::NUM_W - ntc_c2m_pkg::D_W){1'b0}}, r2_d}
                  * ntc_c2m_pkg::NUM_W'(ntc_c2m_pkg::STEP_MILLI);

    always_ff @(posedge i_clk) begin
        if (i_en.en[3]) begin
            r3_num  <= w_num;
            r3_q0   <= w_prod[ntc_c2m_pkg::RECIP_SHIFT +: ntc_c2m_pkg::Q_W];
            r3_span <= r2_span;
            r3_base <= r2_base;
            r3_lo   <= r2_lo;
            r3_hi   <= r2_hi;
        end
    end

    // Stage 4: back-multiply the estimate
    logic [ntc_c2m_pkg::QS_W-1:0]   w_qs;
    logic [ntc_c2m_pkg::QS_W-1:0]   r4_qs;
    logic [ntc_c2m_pkg::NUM_W-1:0]  r4_num;
    logic [ntc_c2m_pkg::Q_W-1:0]    r4_q0;
    logic [ntc_c2m_pkg::SPAN_W-1:0] r4_span;
    logic signed [TW-1:0]           r4_base;
    logic                           r4_lo;
    logic                           r4_hi;

    assign w_qs = {{ntc_c2m_pkg::SPAN_W{1'b0}}, r3_q0}
                * {{ntc_c2m_pkg::Q_W{1'b0}}, r3_span};

    always_ff @(posedge i_clk) begin
        if (i_en.en[4]) begin
            r4_qs   <= w_qs;
            r4_num  <= r3_num;
            r4_q0   <= r3_q0;
            r4_span <= r3_span;
            r4_base <= r3_base;
            r4_lo   <= r3_lo;
            r4_hi   <= r3_hi;
        end
    end

    // Stage 5: remainder; estimate is exact or one short
    logic [ntc_c2m_pkg::QS_W-1:0]   w_rem_full;
    logic [ntc_c2m_pkg::SPAN_W:0]   w_rem;
    logic                           w_ge;
    logic [ntc_c2m_pkg::Q_W-1:0]    r5_q;
    logic                           r5_rnz;
    logic signed [TW-1:0]           r5_base;
    logic                           r5_lo;
    logic                           r5_hi;

    assign w_rem_full = {{(ntc_c2m_pkg::QS_W - ntc_c2m_pkg::NUM_W){1'b0}}, r4_num} - r4_qs;
    assign w_rem      = w_rem_full[ntc_c2m_pkg::SPAN_W:0];
    assign w_ge       = (w_rem >= {1'b0, r4_span});

    always_ff @(posedge i_clk) begin
        if (i_en.en[5]) begin
            r5_q    <= w_ge ? r4_q0 + ntc_c2m_pkg::Q_W'(1) : r4_q0;
            r5_rnz  <= w_ge ? (w_rem != {1'b0, r4_span}) : (w_rem != '0);
            r5_base <= r4_base;
            r5_lo   <= r4_lo;
            r5_hi   <= r4_hi;
        end
    end

    // Stage 6: add segment base or pick the clamp value; a negative inexact result truncates up
    logic signed [TW-1:0] w_sum;
    logic signed [TW-1:0] r6_temp;
    logic                 r6_clamped;

    assign w_sum = r5_base
                 + signed'({{(TW - ntc_c2m_pkg::Q_W){1'b0}}, r5_q})
                 + signed'({{(TW - 1){1'b0}}, r5_base[TW-1] & r5_rnz});

    always_ff @(posedge i_clk) begin
        if (i_en.en[6]) begin
            if (r5_lo) begin
                r6_temp <= TW'(ntc_c2m_pkg::BASE_MILLI);
            end else if (r5_hi) begin
                r6_temp <= TW'(HI_TEMP);
            end else begin
                r6_temp <= w_sum;
            end
            r6_clamped <= r5_lo | r5_hi;
        end
    end

    assign o_temp_millideg = r6_temp;
    assign o_clamped       = r6_clamped;

endmodule

[src/ntc_code_to_millidegree_top.sv]
// NTC code to millidegree converter.
// Input channel i_in carries one 16-bit converter code per beat; output
// channel o_out carries the temperature in millidegrees Celsius (19-bit
// signed) and a clamp flag. Both use valid/ready; a beat moves when both
// are high.
// Codes at or below the first breakpoint give -40000, codes above the last
// used breakpoint give that breakpoint's temperature; both raise clamped.
// Within a segment the value is interpolated and truncated toward zero.
// From input beat to output beat a code passes compare, segment encode,
// table lookup, reciprocal multiply, back-multiply, remainder fix and base
// add, in that order. One beat per cycle is sustained while the receiver
// holds ready high, and then the seven pipeline registers each take a new
// beat every cycle.
// When the receiver holds ready low the output register keeps its beat and
// earlier stages keep filling any empty slots; i_in.ready drops only once
// every stage is full. Nothing is lost or repeated.
// Reset clears all stage valid bits; no table or clearing pass is needed.
module ntc_code_to_millidegree_top #(
    parameter int TABLE_POINTS = ntc_c2m_pkg::TABLE_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ntc_c2m_in_if.sink           i_in,
    ntc_c2m_out_if.source        o_out
);

    // Usable breakpoints: at least two, at most the stored table
    localparam int POINTS = (TABLE_POINTS > ntc_c2m_pkg::STORED_POINTS)
                          ? ntc_c2m_pkg::STORED_POINTS
                          : ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
    localparam int HI_TEMP = ntc_c2m_pkg::BASE_MILLI
                           + ntc_c2m_pkg::STEP_MILLI * (POINTS - 1);

    ntc_c2m_pkg::t_pipe_en   w_en;
    ntc_c2m_pkg::t_seg_beat  w_beat;
    logic                    w_in_ready;
    logic                    w_out_valid;

    // Stage valids and load enables
    ntc_c2m_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .o_en        (w_en)
    );

    // Breakpoint search
    ntc_c2m_search #(.POINTS(POINTS)) u_search (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_raw_code (i_in.raw_code),
        .o_beat     (w_beat)
    );

    // Interpolation
    ntc_c2m_interp #(.POINTS(POINTS)) u_interp (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_beat          (w_beat),
        .o_temp_millideg (o_out.temp_millideg),
        .o_clamped       (o_out.clamped)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;

    // A clamped beat carries one of the two end temperatures
    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.clamped) |->
            (o_out.temp_millideg == ntc_c2m_pkg::TEMP_W'(ntc_c2m_pkg::BASE_MILLI) ||
             o_out.temp_millideg == ntc_c2m_pkg::TEMP_W'(HI_TEMP)))
        else $error("clamped beat with inner temperature");

    // Interpolated results stay inside the table's range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.clamped) |->
            (o_out.temp_millideg >= ntc_c2m_pkg::TEMP_W'(ntc_c2m_pkg::BASE_MILLI) &&
             o_out.temp_millideg <= ntc_c2m_pkg::TEMP_W'(HI_TEMP)))
        else $error("interpolated temperature out of range");

    // An empty output register means the pipe can take a beat
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");

    // Nothing is presented straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid after reset");

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINTS     = ntc_c2m_pkg::TABLE_POINTS_DEF;
    localparam int N_RANDOM   = 400;
    localparam int N_CALM     = 60;
    localparam int HOLD_LEN   = 80;
    localparam int STALL_MAX  = 2000;

    // One expected conversion
    typedef struct packed {
        logic signed [ntc_c2m_pkg::TEMP_W-1:0] temp;
        logic                                  clamp;
    } t_temp;

    // Directed row: typed expectation where it is obvious, else predicted
    typedef struct {
        logic [ntc_c2m_pkg::CODE_W-1:0] code;
        bit                             typed;
        int                             temp;
        bit                             clamp;
    } t_code_row;

    localparam int N_DIRECTED = 22;
    t_code_row directed_codes [N_DIRECTED] = '{
        '{16'd0,     1'b1, -40000, 1'b1},   // zero code
        '{16'd1,     1'b0, 0,      1'b0},
        '{16'd7,     1'b1, -40000, 1'b1},   // exactly on first breakpoint
        '{16'd8,     1'b0, 0,      1'b0},   // negative value truncates upwards
        '{16'd9,     1'b0, 0,      1'b0},
        '{16'd10,    1'b1, -35000, 1'b0},   // inner breakpoint
        '{16'd11,    1'b0, 0,      1'b0},
        '{16'd500,   1'b0, 0,      1'b0},
        '{16'd588,   1'b1, 60000,  1'b0},
        '{16'd587,   1'b0, 0,      1'b0},
        '{16'd945,   1'b1, 125000, 1'b0},
        '{16'd982,   1'b0, 0,      1'b0},
        '{16'd983,   1'b1, 150000, 1'b0},
        '{16'd984,   1'b0, 0,      1'b0},   // widest segment
        '{16'd2000,  1'b0, 0,      1'b0},
        '{16'd4095,  1'b0, 0,      1'b0},
        '{16'd4096,  1'b1, 155000, 1'b0},   // last breakpoint, still in table
        '{16'd4097,  1'b1, 155000, 1'b1},   // just above table
        '{16'h5555,  1'b1, 155000, 1'b1},
        '{16'hAAAA,  1'b1, 155000, 1'b1},
        '{16'h7FFF,  1'b1, 155000, 1'b1},
        '{16'hFFFF,  1'b1, 155000, 1'b1}
    };

    logic i_clk;
    logic i_rst_n;

    ntc_c2m_in_if  in_if ();
    ntc_c2m_out_if out_if ();

    ntc_code_to_millidegree_top #(
        .TABLE_POINTS (POINTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_temp pending_temps [$];
    int    mismatch_count = 0;
    int    codes_sent     = 0;
    bit    calm           = 1'b0;
    bit    hold_off       = 1'b0;
    bit    all_sent       = 1'b0;

    // Piecewise-linear interpolation over the breakpoint table
    function automatic t_temp interpolate_code(logic [ntc_c2m_pkg::CODE_W-1:0] code);
        t_temp  r;
        int     n;
        int     seg;
        longint lo;
        longint hi;
        longint span;
        longint base;
        longint num;
        n = (POINTS > ntc_c2m_pkg::STORED_POINTS) ? ntc_c2m_pkg::STORED_POINTS : POINTS;
        if (n < 2) n = 2;
        if (code <= ntc_c2m_pkg::NTC_CODES[0]) begin
            r.temp  = ntc_c2m_pkg::TEMP_W'(ntc_c2m_pkg::BASE_MILLI);
            r.clamp = 1'b1;
        end else if (code > ntc_c2m_pkg::NTC_CODES[n-1]) begin
            r.temp  = ntc_c2m_pkg::TEMP_W'(ntc_c2m_pkg::BASE_MILLI
                                         + ntc_c2m_pkg::STEP_MILLI * (n - 1));
            r.clamp = 1'b1;
        end else begin
            seg = 1;
            while (seg < n - 1 && code > ntc_c2m_pkg::NTC_CODES[seg]) seg++;
            lo   = longint'(ntc_c2m_pkg::NTC_CODES[seg-1]);
            hi   = longint'(ntc_c2m_pkg::NTC_CODES[seg]);
            span = hi - lo;
            if (span <= 0) span = 1;
            base = longint'(ntc_c2m_pkg::BASE_MILLI)
                 + longint'(ntc_c2m_pkg::STEP_MILLI) * (seg - 1);
            num  = base * span
                 + longint'(ntc_c2m_pkg::STEP_MILLI) * (longint'(code) - lo);
            // signed division truncates toward zero
            r.temp  = ntc_c2m_pkg::TEMP_W'(num / span);
            r.clamp = 1'b0;
        end
        return r;
    endfunction

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reset, held low at start and then released
    initial begin
        i_rst_n = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Code sender: directed rows, then random codes
    initial begin
        logic [ntc_c2m_pkg::CODE_W-1:0] code;
        t_temp                          want;
        int                             gap;
        int                             pick;
        int                             idle_pct;
        in_if.valid    = 1'b0;
        in_if.raw_code = '0;
        idle_pct       = 20;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        for (int idx = 0; idx < N_DIRECTED + N_RANDOM; idx++) begin
            if (idx >= N_DIRECTED + N_RANDOM - N_CALM) calm = 1'b1;
            if ($urandom_range(0, 15) == 0) begin
                pick     = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            end
            if (idx < N_DIRECTED) begin
                code = directed_codes[idx].code;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)      code = ntc_c2m_pkg::CODE_W'($urandom_range(8, 983));
                else if (pick < 80) code = ntc_c2m_pkg::CODE_W'($urandom_range(0, 10));
                else if (pick < 90) code = ntc_c2m_pkg::CODE_W'($urandom_range(980, 4100));
                else                code = ntc_c2m_pkg::CODE_W'($urandom);
            end
            // idle burst before the beat
            if (!calm && !hold_off && $urandom_range(0, 99) < idle_pct) begin
                gap = $urandom_range(1, 14);
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid    <= 1'b1;
            in_if.raw_code <= code;
            @(posedge i_clk);
            while (in_if.ready !== 1'b1) @(posedge i_clk);
            if (idx < N_DIRECTED && directed_codes[idx].typed) begin
                want.temp  = ntc_c2m_pkg::TEMP_W'(directed_codes[idx].temp);
                want.clamp = directed_codes[idx].clamp;
            end else begin
                want = interpolate_code(code);
            end
            pending_temps.push_back(want);
            codes_sent++;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b0;
        all_sent = 1'b1;
    end

    // Receiver: random stall bursts plus one long hold-off
    initial begin
        int  stall;
        int  idle_pct;
        int  cycles;
        int  pick;
        bit  pressed;
        out_if.ready = 1'b0;
        stall    = 0;
        idle_pct = 20;
        cycles   = 0;
        pressed  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cycles++;
            if (cycles % 64 == 0) begin
                pick     = $urandom_range(0, 2);
                idle_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            end
            if (!pressed && codes_sent >= 40) begin
                // long hold so the pipeline fills and back-pressures the input
                pressed  = 1'b1;
                hold_off = 1'b1;
                stall    = HOLD_LEN;
            end else if (stall == 0) begin
                hold_off = 1'b0;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    stall = $urandom_range(1, 14);
            end
            if (stall > 0) begin
                stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_temp want;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_temps.size() == 0) begin
                $display("%0t: unexpected result temp=%0d clamped=%0b",
                         $time, out_if.temp_millideg, out_if.clamped);
                mismatch_count++;
            end else begin
                want = pending_temps.pop_front();
                if (out_if.temp_millideg !== want.temp) begin
                    $display("%0t: temp_millideg expected %0d actual %0d",
                             $time, want.temp, out_if.temp_millideg);
                    mismatch_count++;
                end
                if (out_if.clamped !== want.clamp) begin
                    $display("%0t: clamped expected %0b actual %0b",
                             $time, want.clamp, out_if.clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        int quiet_cycles;
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // End of run
    initial begin
        wait (all_sent);
        while (pending_temps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
